FILE: rtl/max_heap_priority_queue_defines.svh
// Assertion macros for the max-heap priority queue.
// Included by the top level; depends on a signal named clock and one named reset.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define MHPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("heap queue check failed");
// Next-cycle implication.
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heap queue check failed");
`else
`define MHPQ_ASSERT_NOW(label, ante, cons)
`define MHPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int QUEUE_DEPTH      = 2;
   localparam int KEY_W            = 32;
   localparam int ENTRIES_W        = 6;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   operation;
      logic signed [KEY_W-1:0]  key_in;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]  removed_key;
      status_type               status;
      logic [ENTRIES_W-1:0]     entries_held;
      logic signed [KEY_W-1:0]  top_key;
   } rsp_type;

   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_UP_RD,
      ENG_UP_CMP,
      ENG_DN_LAST_RD,
      ENG_DN_LAST,
      ENG_DN_RD,
      ENG_DN_CMP,
      ENG_WR_KEY,
      ENG_EMIT
   } eng_state_type;

endpackage

`default_nettype wire

FILE: rtl/mhpq_fifo.sv
// Small register queue used on both sides of the heap engine.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] din,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      dout
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mhpq_engine.sv
// Heap engine: takes commands from the request queue, sifts keys through the
// heap memory and writes one result per command. Depends on mhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_engine #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_empty,
   input  wire mhpq_pkg::req_type cmd_item,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output mhpq_pkg::rsp_type      rsp_item
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = mhpq_pkg::KEY_W;

   mhpq_pkg::eng_state_type state_ff, state_in;

   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic signed [KW-1:0]  key_ff, key_in;
   logic signed [KW-1:0]  root_ff, root_in;
   logic signed [KW-1:0]  removed_ff, removed_in;
   mhpq_pkg::status_type  status_ff, status_in;

   logic signed [KW-1:0]  heap_mem [CAPACITY];
   logic signed [KW-1:0]  rd_a_ff, rd_b_ff;
   logic [AW-1:0]         rd_addr_a, rd_addr_b;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic signed [KW-1:0]  mem_wdata;

   // Tree navigation from the current hole position.
   logic [AW-1:0]         parent_idx;
   logic [AW:0]           left_idx, right_idx;
   logic                  left_ok, right_ok;
   logic signed [KW-1:0]  big_val;
   logic                  take_left, take_right;
   logic [AW-1:0]         child_idx;
   logic signed [KW-1:0]  child_val;

   assign parent_idx = (pos_ff - 1'b1) >> 1;
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = {pos_ff, 1'b0} + 1'b1 + 1'b1;
   assign left_ok    = left_idx < (AW + 1)'(count_ff);
   assign right_ok   = right_idx < (AW + 1)'(count_ff);
   assign take_left  = key_ff < rd_a_ff;
   assign big_val    = take_left ? rd_a_ff : key_ff;
   assign take_right = right_ok && (big_val < rd_b_ff);
   assign child_idx  = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
   assign child_val  = take_right ? rd_b_ff : rd_a_ff;

   // Next state and register updates.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      key_in     = key_ff;
      root_in    = root_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      case (state_ff)
         mhpq_pkg::ENG_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               removed_in = '0;
               status_in  = mhpq_pkg::ST_DONE;
               if (cmd_item.operation == mhpq_pkg::OP_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = mhpq_pkg::ST_FULL;
                     state_in  = mhpq_pkg::ENG_EMIT;
                  end else begin
                     key_in   = cmd_item.key_in;
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + 1'b1;
                     state_in = (count_ff == '0) ? mhpq_pkg::ENG_WR_KEY
                                                 : mhpq_pkg::ENG_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = mhpq_pkg::ST_EMPTY;
                     state_in  = mhpq_pkg::ENG_EMIT;
                  end else begin
                     removed_in = root_ff;
                     count_in   = count_ff - 1'b1;
                     state_in   = (count_ff == CW'(1)) ? mhpq_pkg::ENG_EMIT
                                                       : mhpq_pkg::ENG_DN_LAST_RD;
                  end
               end
            end
         end
         mhpq_pkg::ENG_UP_RD: begin
            state_in = mhpq_pkg::ENG_UP_CMP;
         end
         mhpq_pkg::ENG_UP_CMP: begin
            if (key_ff > rd_a_ff) begin
               pos_in   = parent_idx;
               state_in = (parent_idx == '0) ? mhpq_pkg::ENG_WR_KEY
                                             : mhpq_pkg::ENG_UP_RD;
            end else begin
               state_in = mhpq_pkg::ENG_WR_KEY;
            end
         end
         mhpq_pkg::ENG_DN_LAST_RD: begin
            state_in = mhpq_pkg::ENG_DN_LAST;
         end
         mhpq_pkg::ENG_DN_LAST: begin
            key_in   = rd_a_ff;
            pos_in   = '0;
            state_in = mhpq_pkg::ENG_DN_RD;
         end
         mhpq_pkg::ENG_DN_RD: begin
            state_in = left_ok ? mhpq_pkg::ENG_DN_CMP : mhpq_pkg::ENG_WR_KEY;
         end
         mhpq_pkg::ENG_DN_CMP: begin
            if (take_left || take_right) begin
               if (pos_ff == '0) begin
                  root_in = child_val;
               end
               pos_in   = child_idx;
               state_in = mhpq_pkg::ENG_DN_RD;
            end else begin
               state_in = mhpq_pkg::ENG_WR_KEY;
            end
         end
         mhpq_pkg::ENG_WR_KEY: begin
            if (pos_ff == '0) begin
               root_in = key_ff;
            end
            state_in = mhpq_pkg::ENG_EMIT;
         end
         mhpq_pkg::ENG_EMIT: begin
            state_in = mhpq_pkg::ENG_IDLE;
         end
         default: begin
            state_in = mhpq_pkg::ENG_IDLE;
         end
      endcase
   end

   // Memory, queue and result controls.
   always_comb begin
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = key_ff;
      rd_addr_a = parent_idx;
      rd_addr_b = parent_idx;
      case (state_ff)
         mhpq_pkg::ENG_IDLE: begin
            cmd_pop = !cmd_empty && !rsp_full;
         end
         mhpq_pkg::ENG_UP_CMP: begin
            if (key_ff > rd_a_ff) begin
               mem_we    = 1'b1;
               mem_wdata = rd_a_ff;
            end
         end
         mhpq_pkg::ENG_DN_LAST_RD: begin
            rd_addr_a = count_ff[AW-1:0];
         end
         mhpq_pkg::ENG_DN_RD: begin
            rd_addr_a = left_idx[AW-1:0];
            rd_addr_b = right_ok ? right_idx[AW-1:0] : left_idx[AW-1:0];
         end
         mhpq_pkg::ENG_DN_CMP: begin
            if (take_left || take_right) begin
               mem_we    = 1'b1;
               mem_wdata = child_val;
            end
         end
         mhpq_pkg::ENG_WR_KEY: begin
            mem_we = 1'b1;
         end
         mhpq_pkg::ENG_EMIT: begin
            rsp_push = 1'b1;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   assign rsp_item.removed_key  = removed_ff;
   assign rsp_item.status       = status_ff;
   assign rsp_item.entries_held = mhpq_pkg::ENTRIES_W'(count_ff);
   assign rsp_item.top_key      = (count_ff == '0) ? '0 : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhpq_pkg::ENG_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      key_ff     <= key_in;
      root_ff    <= root_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

endmodule

`default_nettype wire

FILE: rtl/max_heap_priority_queue.sv
// Top level of the bounded max-heap priority queue: request queue, heap
// engine and result queue. Depends on mhpq_pkg, mhpq_fifo, mhpq_engine.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_push/req_full  req_item (mhpq_pkg::req_type)
//   rsp_      out        rsp_pop/rsp_empty  rsp_item (mhpq_pkg::rsp_type)
//
// Each item is worked on alone by the engine, which owns a single heap memory
// with one write and two registered read ports. The engine goes straight to
// its result on a rejected insert or delete and on a delete that empties the
// heap. An insert compares the key with each parent on its way up, moving the
// parent down while the key is greater. A delete that leaves keys moves the
// last key to the root and sifts it down, reading both children, comparing and
// writing the larger child up per level, through at most log2 of CAPACITY
// levels, until the key stops or reaches a node with no child.
// An item reaches the engine only once it is registered in the request queue.
// Reset clears the queues and the entry count; the heap memory is not cleared,
// since no slot beyond the count is ever used.
// The request queue takes items while the engine works, until it is full, and
// the result queue holds finished results while the consumer stalls.
`timescale 1ns / 1ps
`default_nettype none
`include "max_heap_priority_queue_defines.svh"

module max_heap_priority_queue #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire mhpq_pkg::req_type req_item,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output mhpq_pkg::rsp_type      rsp_item
);

   localparam int REQ_W = $bits(mhpq_pkg::req_type);
   localparam int RSP_W = $bits(mhpq_pkg::rsp_type);

   logic              cmd_empty;
   logic              cmd_pop;
   logic [REQ_W-1:0]  cmd_bits;
   mhpq_pkg::req_type cmd_item;
   logic              res_full;
   logic              res_push;
   mhpq_pkg::rsp_type res_item;
   logic [RSP_W-1:0]  rsp_bits;
   logic              rsp_rej_full;
   logic              rsp_rej_empty;
   logic              rsp_no_keys;

   assign cmd_item = mhpq_pkg::req_type'(cmd_bits);
   assign rsp_item = mhpq_pkg::rsp_type'(rsp_bits);

   // Front: holds accepted items until the engine is free.
   mhpq_fifo #(
      .WIDTH (REQ_W),
      .DEPTH (mhpq_pkg::QUEUE_DEPTH)
   ) u_req_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .din   (REQ_W'(req_item)),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .dout  (cmd_bits)
   );

   // Back: the heap itself.
   mhpq_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_item  (res_item)
   );

   // Results wait here so the engine never stalls on the consumer mid-item.
   mhpq_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (mhpq_pkg::QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .full  (res_full),
      .din   (RSP_W'(res_item)),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .dout  (rsp_bits)
   );

   assign rsp_rej_full  = !rsp_empty && (rsp_item.status == mhpq_pkg::ST_FULL);
   assign rsp_rej_empty = !rsp_empty && (rsp_item.status == mhpq_pkg::ST_EMPTY);
   assign rsp_no_keys   = (rsp_item.top_key == '0) && (rsp_item.removed_key == '0);

   // A rejected insert never reports a removed key.
   `MHPQ_ASSERT_NOW(a_full_no_removed, rsp_rej_full, rsp_item.removed_key == '0)
   // A rejected delete means the heap was and stays empty.
   `MHPQ_ASSERT_NOW(a_empty_reject, rsp_rej_empty, rsp_no_keys)
   // The engine writes a result only when the result queue has room.
   `MHPQ_ASSERT_NOW(a_push_room, res_push, !res_full)

endmodule

`default_nettype wire
